// ----- src/dq_pkg.sv -----
package dq_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WW    = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  // (base + off) mod DEPTH; base < DEPTH and off < DEPTH
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// ----- src/double_ended_queue.sv -----
// Double-ended queue of signed 32-bit words held in a single-port ring buffer.
// A command accepted at a clock edge gives its result strobe in the next
// cycle; busy is high during that cycle.
// No new command is taken while busy is high, so each command finishes
// before the next one is accepted; the store's read is registered.
// Reset (rst_n low, synchronous): queue empty, head index 0, no strobe.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic signed [WW-1:0] in_push_value,
  output logic                 out_valid,
  output logic signed [WW-1:0] out_popped_value,
  output logic [1:0]           out_status,
  output logic [CW-1:0]        out_entry_count
);

  // control state
  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // result registers, captured at acceptance
  status_t       status_r, status_nxt;
  logic          pop_ok_r, pop_ok_nxt;

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [WW-1:0] mem_rdata;

  logic accept;
  logic is_full;
  logic is_empty;
  cmd_t cmd;

  assign accept   = start && !busy;
  assign cmd      = cmd_t'(in_command);
  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // Command decode: one store access per transaction. Pushes write at the
  // accept edge; pops read there and the word is on mem_rdata next cycle.
  // Since busy blocks the cycle after acceptance, a read never meets the
  // write of the previous transaction, so no forwarding path is needed.
  // The receiver cannot stall: each result is shown for exactly one cycle.
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    mem_we     = 1'b0;
    mem_addr   = head_r;
    if (accept) begin
      status_nxt = STATUS_OK;
      pop_ok_nxt = 1'b0;
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          // front moves one slot back, new word lands there
          mem_addr = ring_add(head_r, CW'(DEPTH - 1));
          if (is_full) begin
            status_nxt = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            head_nxt  = mem_addr;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          // slot just past the back entry; count < DEPTH whenever it is used
          mem_addr = ring_add(head_r, count_r);
          if (is_full) begin
            status_nxt = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          mem_addr = head_r;
          if (is_empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            pop_ok_nxt = 1'b1;
            head_nxt   = ring_add(head_r, CW'(1));
            count_nxt  = count_r - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          // back entry at head + count - 1; address ignored when empty
          mem_addr = ring_add(head_r, count_r - CW'(1));
          if (is_empty) begin
            status_nxt = STATUS_EMPTY;
          end else begin
            pop_ok_nxt = 1'b1;
            count_nxt  = count_r - CW'(1);
          end
        end
        default: begin
          status_nxt = STATUS_OK;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // FSM outputs
  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
      ST_RESP: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        busy      = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // payload side of the result, no reset needed
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    pop_ok_r <= pop_ok_nxt;
  end

  dq_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_push_value),
    .rdata (mem_rdata)
  );

  // count_r already holds the post-command count during the strobe cycle
  assign out_popped_value = pop_ok_r ? mem_rdata : '0;
  assign out_status       = status_r;
  assign out_entry_count  = count_r;

  // every accepted transaction gives exactly one strobe, in the cycle after
  a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result after accepted command");

  a_resp_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result strobe without accepted command");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_EMPTY) |-> (out_entry_count == '0))
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_FULL) |-> (out_entry_count == CW'(DEPTH)))
    else $error("full status with free slots");

endmodule

// ----- src/dq_ram.sv -----
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- tb/tb_double_ended_queue.sv -----
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import dq_pkg::*;

  // Stall watchdog: cycles in a row with no transaction on either side.
  localparam int IDLE_LIMIT = 2000;
  // Random commands after the directed opening.
  localparam int RAND_ITEMS = 1130;

  // One command as it goes into the block.
  typedef struct {
    cmd_t                 cmd;
    logic signed [WW-1:0] word;
  } deque_cmd_t;

  // One result as it comes out of the block.
  typedef struct {
    logic signed [WW-1:0] popped;
    status_t              status;
    logic [CW-1:0]        count;
  } deque_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_command;
  logic signed [WW-1:0] in_push_value;
  logic                 out_valid;
  logic signed [WW-1:0] out_popped_value;
  logic [1:0]           out_status;
  logic [CW-1:0]        out_entry_count;

  double_ended_queue u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  // Commands waiting to be sent, and results the block still owes us.
  deque_cmd_t    cmd_backlog[$];
  deque_result_t owed_results[$];

  // Shadow deque: ring store, front slot, number of words held.
  logic signed [WW-1:0] shadow_ring [DEPTH];
  logic [AW-1:0]        shadow_front;
  logic [CW-1:0]        shadow_held;

  int error_count;
  int idle_cycles;
  int burst_left;
  int gap_left;
  int n_push_ok;
  int n_pop_ok;
  int n_full;
  int n_empty;
  int peak_held;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Updates the shadow deque for one command and gives the result it implies.
  // Full push and empty pop leave the state alone.
  task automatic deque_next(input cmd_t cmd, input logic signed [WW-1:0] word,
                            output deque_result_t res);
    logic [AW-1:0] slot;
    res.popped = '0;
    res.status = STATUS_OK;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (int'(shadow_held) >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          // front moves back one slot, wrapping below zero
          shadow_front = AW'((int'(shadow_front) + DEPTH - 1) % DEPTH);
          shadow_ring[shadow_front] = word;
          shadow_held = shadow_held + 1'b1;
        end else begin
          slot = AW'((int'(shadow_front) + int'(shadow_held)) % DEPTH);
          shadow_ring[slot] = word;
          shadow_held = shadow_held + 1'b1;
        end
      end
      default: begin
        if (shadow_held == '0) begin
          res.status = STATUS_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          res.popped = shadow_ring[shadow_front];
          shadow_front = AW'((int'(shadow_front) + 1) % DEPTH);
          shadow_held = shadow_held - 1'b1;
        end else begin
          slot = AW'((int'(shadow_front) + int'(shadow_held) - 1) % DEPTH);
          res.popped = shadow_ring[slot];
          shadow_held = shadow_held - 1'b1;
        end
      end
    endcase
    res.count = shadow_held;
  endtask

  // Driver: works off the backlog at the falling edge, in bursts with gaps.
  // While idle the data ports carry noise, which the block must ignore.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0 || cmd_backlog.size() == 0) begin
      start         <= 1'b0;
      in_command    <= 2'($urandom);
      in_push_value <= $urandom;
      if (gap_left > 0) gap_left--;
    end else begin
      start         <= 1'b1;
      in_command    <= cmd_backlog[0].cmd;
      in_push_value <= cmd_backlog[0].word;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 40);
        // about one burst in four runs straight into the next
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
  end

  // Monitor: takes both transactions at the rising edge, before the block's
  // outputs move.
  always @(posedge clk) begin
    deque_result_t got_res;
    deque_result_t want;
    logic          moved;
    moved = 1'b0;
    if (rst_n && start && !busy) begin
      moved = 1'b1;
      deque_next(cmd_t'(in_command), in_push_value, got_res);
      owed_results.push_back(got_res);
      void'(cmd_backlog.pop_front());
      case (got_res.status)
        STATUS_FULL:  n_full++;
        STATUS_EMPTY: n_empty++;
        default: begin
          if (in_command[1]) n_pop_ok++;
          else n_push_ok++;
        end
      endcase
      if (int'(shadow_held) > peak_held) peak_held = int'(shadow_held);
    end
    if (rst_n && out_valid) begin
      moved = 1'b1;
      if (owed_results.size() == 0) begin
        $display("%0t: result with nothing expected: popped %0d status %0d count %0d",
                 $time, out_popped_value, out_status, out_entry_count);
        error_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_popped_value !== want.popped) begin
          $display("%0t: popped_value expected %0d actual %0d",
                   $time, want.popped, out_popped_value);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.count, out_entry_count);
          error_count++;
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog on a stalled handshake.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("tb_double_ended_queue: errors");
    $finish;
  end

  // Stimulus, reset and the end of the run.
  initial begin
    deque_cmd_t one;
    int         made;
    int         mode;
    int         seg_len;
    int         push_pct;

    start         = 1'b0;
    in_command    = '0;
    in_push_value = '0;
    rst_n         = 1'b0;
    shadow_front  = '0;
    shadow_held   = '0;
    error_count   = 0;
    idle_cycles   = 0;
    burst_left    = 1;
    gap_left      = 0;
    n_push_ok     = 0;
    n_pop_ok      = 0;
    n_full        = 0;
    n_empty       = 0;
    peak_held     = 0;

    // Directed: pops on empty from both ends, push front from head 0 (wraps
    // to the top slot), word extremes, both pop ends, draining back to empty.
    one.cmd = CMD_POP_FRONT;  one.word = 32'sh7fffffff; cmd_backlog.push_back(one);
    one.cmd = CMD_POP_BACK;   one.word = 32'sh80000000; cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_FRONT; one.word = 32'sh7fffffff; cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_BACK;  one.word = 32'sh80000000; cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_FRONT; one.word = -32'sd1;       cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_BACK;  one.word = 32'sd0;        cmd_backlog.push_back(one);
    one.cmd = CMD_POP_BACK;   one.word = -32'sd1;       cmd_backlog.push_back(one);
    one.cmd = CMD_POP_FRONT;  one.word = 32'sd0;        cmd_backlog.push_back(one);
    one.cmd = CMD_POP_FRONT;  one.word = 32'sh55555555; cmd_backlog.push_back(one);
    one.cmd = CMD_POP_BACK;   one.word = 32'shaaaaaaaa; cmd_backlog.push_back(one);
    one.cmd = CMD_POP_BACK;   one.word = 32'sd0;        cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_BACK;  one.word = 32'sh55555555; cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_BACK;  one.word = 32'shaaaaaaaa; cmd_backlog.push_back(one);
    one.cmd = CMD_PUSH_FRONT; one.word = 32'sd1;        cmd_backlog.push_back(one);
    one.cmd = CMD_POP_FRONT;  one.word = -32'sd1;       cmd_backlog.push_back(one);
    one.cmd = CMD_POP_BACK;   one.word = 32'sd0;        cmd_backlog.push_back(one);
    one.cmd = CMD_POP_FRONT;  one.word = 32'sd0;        cmd_backlog.push_back(one);
    one.cmd = CMD_POP_FRONT;  one.word = 32'sd0;        cmd_backlog.push_back(one);

    // Random: segments that lean toward filling, draining or neither, so the
    // queue hits full and empty many times and wraps at both ends.
    made = 0;
    while (made < RAND_ITEMS) begin
      mode     = $urandom_range(0, 2);
      seg_len  = $urandom_range(16, 140);
      push_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      for (int k = 0; k < seg_len && made < RAND_ITEMS; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          one.cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          one.cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        end
        case ($urandom_range(0, 15))
          0:       one.word = 32'sh80000000;
          1:       one.word = 32'sh7fffffff;
          2:       one.word = 32'sd0;
          3:       one.word = -32'sd1;
          default: one.word = $urandom;
        endcase
        cmd_backlog.push_back(one);
        made++;
      end
    end

    // synchronous reset, released away from the rising edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || owed_results.size() != 0) @(posedge clk);
    // then wait on to catch any stray strobe
    repeat (4) @(posedge clk);

    $display("covered %0d good pushes, %0d good pops, %0d pushes on full, %0d pops on empty",
             n_push_ok, n_pop_ok, n_full, n_empty);
    $display("deepest fill %0d of %0d entries, %0d mismatches", peak_held, DEPTH, error_count);
    if (error_count == 0) begin
      $display("tb_double_ended_queue: clean");
    end else begin
      $display("tb_double_ended_queue: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dq_pkg.sv
src/dq_ram.sv
src/double_ended_queue.sv
tb/tb_double_ended_queue.sv
